// ----- hdl/btw_pkg.sv -----
`default_nettype none
package btw_pkg;

   localparam int TIME_W    = 48;
   localparam int EXT_W     = TIME_W + 1;
   localparam int ID_W      = 6;
   localparam int CFG_W     = 21;
   localparam int OP_W      = 2;
   localparam int ST_W      = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   localparam logic [ST_W-1:0] ST_INSERTED    = 3'd0;
   localparam logic [ST_W-1:0] ST_REMOVED     = 3'd1;
   localparam logic [ST_W-1:0] ST_NOT_ARMED   = 3'd2;
   localparam logic [ST_W-1:0] ST_FIRED       = 3'd3;
   localparam logic [ST_W-1:0] ST_NOTHING_DUE = 3'd4;
   localparam logic [ST_W-1:0] ST_TOO_FAR     = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EARLY_WINDOW = 2'd1;

   localparam logic [CFG_W-1:0] BUCKET_WIDTH_RST = 21'd1000;
   localparam logic [CFG_W-1:0] EARLY_WINDOW_RST = 21'd500;

   typedef enum logic [1:0] {
      K_INSERT,
      K_REMOVE,
      K_TICK,
      K_NOP
   } kind_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ID_W-1:0]   timer_id;
      logic [TIME_W-1:0] expiry_us;
      logic [TIME_W-1:0] latest_us;
      logic [TIME_W-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [ID_W-1:0]   out_timer_id;
      logic [TIME_W-1:0] bucket_time_us;
      logic              last;
   } rsp_type;

   typedef struct packed {
      kind_type kind;
      logic     bad_id;
      logic     spread;
      req_type  req;
   } item_type;

endpackage
`default_nettype wire

// ----- hdl/btw_front.sv -----
`default_nettype none
module btw_front import btw_pkg::*; #(
   parameter int MAX_TIMERS = 64
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   output logic          q_valid,
   output item_type      q_item,
   input  wire logic     q_pop
);

   item_type   cls;
   item_type   ent_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] cnt_ff;
   logic       push;

   // classify on the way in
   always_comb begin
      cls.req    = req_data;
      cls.bad_id = ({1'b0, req_data.timer_id} >= (ID_W+1)'(MAX_TIMERS));
      cls.spread = (req_data.latest_us != '0) && (req_data.latest_us > req_data.expiry_us);
      unique case (req_data.opcode)
         OP_INSERT: cls.kind = K_INSERT;
         OP_REMOVE: cls.kind = K_REMOVE;
         OP_TICK:   cls.kind = K_TICK;
         default:   cls.kind = K_NOP;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = ent_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (q_pop) begin
            rptr_ff <= ~rptr_ff;
         end
         priority if (push && !q_pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (!push && q_pop) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hdl/btw_div.sv -----
`default_nettype none
module btw_div import btw_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [EXT_W-1:0] dividend,
   input  wire logic [CFG_W-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic [EXT_W-1:0]      quot,
   output logic [CFG_W-1:0]      rem
);

   localparam int STEP_W = $clog2(EXT_W + 1);

   logic [EXT_W-1:0]  q_ff;
   logic [CFG_W-1:0]  r_ff;
   logic [CFG_W-1:0]  d_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CFG_W:0]    trial;
   logic [CFG_W:0]    diff;
   logic              fits;

   // one quotient bit per cycle, restoring
   assign trial = {r_ff, q_ff[EXT_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = (trial >= {1'b0, d_ff});

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         r_ff <= fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
         q_ff <= {q_ff[EXT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(EXT_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- hdl/btw_back.sv -----
`default_nettype none
module btw_back import btw_pkg::*; #(
   parameter int NUM_SLOTS  = 256,
   parameter int MAX_TIMERS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire item_type         q_item,
   output logic                  q_pop,
   input  wire logic [CFG_W-1:0] width_eff,
   input  wire logic [CFG_W-1:0] early_window,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int TW = $clog2(MAX_TIMERS);
   localparam int CW = $clog2(MAX_TIMERS + 1);
   localparam int NW = $clog2(NUM_SLOTS + 1);
   localparam logic [EXT_W-1:0] TIME_MAX  = {1'b0, {TIME_W{1'b1}}};
   localparam logic [SW-1:0]    LAST_SLOT = SW'(NUM_SLOTS - 1);
   localparam logic [NW-1:0]    SLOT_CNT  = NW'(NUM_SLOTS);

   typedef enum logic [4:0] {
      B_CLEAR, B_IDLE, B_UNL0, B_UNL1, B_UNL2,
      B_DIV_EXP, B_DIV_NOW, B_DIV_LAT,
      B_SPR_RD, B_SPR_EV, B_PLACE_RD, B_PLACE,
      B_SCAN, B_DUE, B_HEAD_RD, B_HEAD, B_EMIT
   } state_type;

   function automatic rsp_type mk_res(input logic [ST_W-1:0] st, input logic [ID_W-1:0] id,
                                      input logic [TIME_W-1:0] t, input logic lst);
      rsp_type r;
      r.status         = st;
      r.out_timer_id   = id;
      r.bucket_time_us = t;
      r.last           = lst;
      return r;
   endfunction

   // slot and timer stores
   logic [CW-1:0]     cnt_mem_ff   [NUM_SLOTS];
   logic [TIME_W-1:0] tag_mem_ff   [NUM_SLOTS];
   logic [TW-1:0]     head_mem_ff  [NUM_SLOTS];
   logic [TW-1:0]     tail_mem_ff  [NUM_SLOTS];
   logic [TW-1:0]     next_mem_ff  [MAX_TIMERS];
   logic [TW-1:0]     prev_mem_ff  [MAX_TIMERS];
   logic [SW-1:0]     tslot_mem_ff [MAX_TIMERS];

   logic [CW-1:0]     cnt_rd_ff;
   logic [TIME_W-1:0] tag_rd_ff;
   logic [TW-1:0]     head_rd_ff;
   logic [TW-1:0]     tail_rd_ff;
   logic [TW-1:0]     next_rd_ff;
   logic [TW-1:0]     prev_rd_ff;
   logic [SW-1:0]     tslot_rd_ff;

   state_type         state_ff;
   state_type         ret_ff;
   item_type          item_ff;
   logic [TW-1:0]     cur_id_ff;
   logic [MAX_TIMERS-1:0] armed_ff;
   rsp_type           res_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic              div_run_ff;
   logic [EXT_W-1:0]  c_ff;
   logic [EXT_W-1:0]  end_ff;
   logic [EXT_W-1:0]  best_ff;
   logic [SW-1:0]     cs_ff;
   logic [SW-1:0]     bs_ff;
   logic [CW-1:0]     least_ff;
   logic              found_ff;
   logic [NW-1:0]     n_ff;
   logic [NW-1:0]     scan_addr_ff;
   logic              scan_pend_ff;
   logic [SW-1:0]     scan_idx_ff;
   logic [TIME_W-1:0] best_tag_ff;
   logic [SW-1:0]     clr_ff;

   logic              out_free;
   logic              div_start;
   logic [EXT_W-1:0]  div_dividend;
   logic [CFG_W-1:0]  div_divisor;
   logic              div_busy;
   logic              div_done;
   logic [EXT_W-1:0]  div_quot;
   logic [CFG_W-1:0]  div_rem;
   logic [EXT_W-1:0]  b_quot;
   logic [TIME_W-1:0] rnd_base;
   logic [EXT_W-1:0]  rnd;
   logic [EXT_W-1:0]  due_lim;
   logic [SW-1:0]     cs_next;
   logic              place_clash;
   logic              spr_better;
   logic              multi;
   logic [SW-1:0]     slot_ra;
   logic [SW-1:0]     slot_wa;
   logic              cnt_we;
   logic [CW-1:0]     cnt_wd;
   logic              tag_we;
   logic              head_we;
   logic [TW-1:0]     head_wd;
   logic              tail_we;
   logic [TW-1:0]     tail_wd;
   logic              next_we;
   logic [TW-1:0]     next_wa;
   logic [TW-1:0]     next_wd;
   logic              prev_we;
   logic [TW-1:0]     prev_wa;
   logic [TW-1:0]     prev_wd;
   logic              tslot_we;
   logic [TW-1:0]     in_idx;

   btw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == B_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign in_idx    = q_item.req.timer_id[TW-1:0];

   assign div_start = !div_run_ff && ((state_ff == B_DIV_EXP) || (state_ff == B_DIV_NOW) ||
                                      (state_ff == B_DIV_LAT));
   assign div_divisor = width_eff;

   always_comb begin
      unique case (state_ff)
         B_DIV_NOW: rnd_base = item_ff.req.now_us;
         B_DIV_LAT: rnd_base = item_ff.req.latest_us;
         default:   rnd_base = item_ff.req.expiry_us;
      endcase
      div_dividend = {1'b0, rnd_base};
   end

   // round up to the next bucket boundary
   assign rnd     = EXT_W'(rnd_base) - EXT_W'(div_rem) + EXT_W'(width_eff);
   // bucket index of the rounded time, slot is its low bits (NUM_SLOTS is a power of two)
   assign b_quot  = div_quot + EXT_W'(1);
   assign due_lim = EXT_W'(item_ff.req.now_us) + EXT_W'(early_window);
   assign cs_next = (cs_ff == LAST_SLOT) ? '0 : cs_ff + SW'(1);

   assign place_clash = (cnt_rd_ff != '0) && (tag_rd_ff != best_ff[TIME_W-1:0]);
   assign spr_better  = ((cnt_rd_ff == '0) || (tag_rd_ff == c_ff[TIME_W-1:0])) &&
                        (!found_ff || (cnt_rd_ff < least_ff));
   assign multi       = (cnt_rd_ff > CW'(1));

   always_comb begin
      unique case (state_ff)
         B_SCAN:   slot_ra = scan_addr_ff[SW-1:0];
         B_SPR_RD: slot_ra = cs_ff;
         B_UNL1:   slot_ra = tslot_rd_ff;
         default:  slot_ra = bs_ff;
      endcase
   end

   always_comb begin
      slot_wa  = bs_ff;
      cnt_we   = 1'b0;
      cnt_wd   = '0;
      tag_we   = 1'b0;
      head_we  = 1'b0;
      head_wd  = cur_id_ff;
      tail_we  = 1'b0;
      tail_wd  = cur_id_ff;
      next_we  = 1'b0;
      next_wa  = tail_rd_ff;
      next_wd  = cur_id_ff;
      prev_we  = 1'b0;
      prev_wa  = cur_id_ff;
      prev_wd  = tail_rd_ff;
      tslot_we = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            slot_wa = clr_ff;
            cnt_we  = 1'b1;
         end
         B_UNL2: begin
            slot_wa = tslot_rd_ff;
            cnt_we  = 1'b1;
            cnt_wd  = multi ? cnt_rd_ff - CW'(1) : '0;
            if (multi) begin
               if (head_rd_ff == cur_id_ff) begin
                  head_we = 1'b1;
                  head_wd = next_rd_ff;
               end else begin
                  next_we = 1'b1;
                  next_wa = prev_rd_ff;
                  next_wd = next_rd_ff;
               end
               if (tail_rd_ff == cur_id_ff) begin
                  tail_we = 1'b1;
                  tail_wd = prev_rd_ff;
               end else begin
                  prev_we = 1'b1;
                  prev_wa = next_rd_ff;
                  prev_wd = prev_rd_ff;
               end
            end
         end
         B_PLACE: begin
            if (!place_clash) begin
               cnt_we   = 1'b1;
               cnt_wd   = cnt_rd_ff + CW'(1);
               tail_we  = 1'b1;
               tslot_we = 1'b1;
               if (cnt_rd_ff == '0) begin
                  tag_we  = 1'b1;
                  head_we = 1'b1;
               end else begin
                  next_we = 1'b1;
                  prev_we = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[slot_wa] <= cnt_wd;
      end
      if (tag_we) begin
         tag_mem_ff[slot_wa] <= best_ff[TIME_W-1:0];
      end
      if (head_we) begin
         head_mem_ff[slot_wa] <= head_wd;
      end
      if (tail_we) begin
         tail_mem_ff[slot_wa] <= tail_wd;
      end
      cnt_rd_ff  <= cnt_mem_ff[slot_ra];
      tag_rd_ff  <= tag_mem_ff[slot_ra];
      head_rd_ff <= head_mem_ff[slot_ra];
      tail_rd_ff <= tail_mem_ff[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem_ff[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem_ff[prev_wa] <= prev_wd;
      end
      if (tslot_we) begin
         tslot_mem_ff[cur_id_ff] <= bs_ff;
      end
      next_rd_ff  <= next_mem_ff[cur_id_ff];
      prev_rd_ff  <= prev_mem_ff[cur_id_ff];
      tslot_rd_ff <= tslot_mem_ff[cur_id_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         armed_ff     <= '0;
         div_run_ff   <= 1'b0;
         scan_pend_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + SW'(1);
               if (clr_ff == LAST_SLOT) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (q_valid) begin
                  item_ff   <= q_item;
                  cur_id_ff <= in_idx;
                  ret_ff    <= B_IDLE;
                  unique case (q_item.kind)
                     K_INSERT: begin
                        priority if (q_item.bad_id) begin
                           res_ff   <= mk_res(ST_TOO_FAR, q_item.req.timer_id, '0, 1'b1);
                           state_ff <= B_EMIT;
                        end else if (armed_ff[in_idx]) begin
                           state_ff <= B_UNL0;
                        end else begin
                           state_ff <= B_DIV_EXP;
                        end
                     end
                     K_REMOVE: begin
                        if (q_item.bad_id || !armed_ff[in_idx]) begin
                           res_ff   <= mk_res(ST_NOT_ARMED, q_item.req.timer_id, '0, 1'b1);
                           state_ff <= B_EMIT;
                        end else begin
                           state_ff <= B_UNL0;
                        end
                     end
                     K_TICK: begin
                        scan_addr_ff <= '0;
                        scan_pend_ff <= 1'b0;
                        found_ff     <= 1'b0;
                        state_ff     <= B_SCAN;
                     end
                     K_NOP: begin
                        res_ff   <= mk_res(ST_NOTHING_DUE, '0, '0, 1'b1);
                        state_ff <= B_EMIT;
                     end
                  endcase
               end
            end
            B_UNL0: state_ff <= B_UNL1;
            B_UNL1: state_ff <= B_UNL2;
            B_UNL2: begin
               armed_ff[cur_id_ff] <= 1'b0;
               unique case (item_ff.kind)
                  K_INSERT: state_ff <= B_DIV_EXP;
                  K_REMOVE: begin
                     res_ff   <= mk_res(ST_REMOVED, ID_W'(cur_id_ff), tag_rd_ff, 1'b1);
                     ret_ff   <= B_IDLE;
                     state_ff <= B_EMIT;
                  end
                  default: begin
                     res_ff   <= mk_res(ST_FIRED, ID_W'(cur_id_ff), tag_rd_ff, !multi);
                     ret_ff   <= multi ? B_HEAD_RD : B_IDLE;
                     state_ff <= B_EMIT;
                  end
               endcase
            end
            B_DIV_EXP: begin
               if (!div_run_ff) begin
                  div_run_ff <= 1'b1;
               end else if (div_done) begin
                  div_run_ff <= 1'b0;
                  if (rnd <= {1'b0, item_ff.req.now_us}) begin
                     state_ff <= B_DIV_NOW;
                  end else begin
                     cs_ff    <= b_quot[SW-1:0];
                     bs_ff    <= b_quot[SW-1:0];
                     best_ff  <= rnd;
                     c_ff     <= rnd;
                     state_ff <= item_ff.spread ? B_DIV_LAT : B_PLACE_RD;
                  end
               end
            end
            B_DIV_NOW: begin
               if (!div_run_ff) begin
                  div_run_ff <= 1'b1;
               end else if (div_done) begin
                  div_run_ff <= 1'b0;
                  cs_ff      <= b_quot[SW-1:0];
                  bs_ff      <= b_quot[SW-1:0];
                  best_ff    <= rnd;
                  c_ff       <= rnd;
                  state_ff   <= item_ff.spread ? B_DIV_LAT : B_PLACE_RD;
               end
            end
            B_DIV_LAT: begin
               if (!div_run_ff) begin
                  div_run_ff <= 1'b1;
               end else if (div_done) begin
                  div_run_ff <= 1'b0;
                  end_ff     <= rnd;
                  found_ff   <= 1'b0;
                  n_ff       <= '0;
                  state_ff   <= B_SPR_RD;
               end
            end
            B_SPR_RD: begin
               if ((n_ff < SLOT_CNT) && (c_ff < end_ff) && (c_ff <= TIME_MAX)) begin
                  state_ff <= B_SPR_EV;
               end else begin
                  state_ff <= B_PLACE_RD;
               end
            end
            B_SPR_EV: begin
               if (spr_better) begin
                  least_ff <= cnt_rd_ff;
                  best_ff  <= c_ff;
                  bs_ff    <= cs_ff;
                  found_ff <= 1'b1;
               end
               if (spr_better && (cnt_rd_ff == '0)) begin
                  state_ff <= B_PLACE_RD;
               end else begin
                  c_ff     <= c_ff + EXT_W'(width_eff);
                  cs_ff    <= cs_next;
                  n_ff     <= n_ff + NW'(1);
                  state_ff <= B_SPR_RD;
               end
            end
            B_PLACE_RD: begin
               if (best_ff > TIME_MAX) begin
                  res_ff   <= mk_res(ST_TOO_FAR, item_ff.req.timer_id, '0, 1'b1);
                  ret_ff   <= B_IDLE;
                  state_ff <= B_EMIT;
               end else begin
                  state_ff <= B_PLACE;
               end
            end
            B_PLACE: begin
               ret_ff   <= B_IDLE;
               state_ff <= B_EMIT;
               if (place_clash) begin
                  res_ff <= mk_res(ST_TOO_FAR, item_ff.req.timer_id, '0, 1'b1);
               end else begin
                  armed_ff[cur_id_ff] <= 1'b1;
                  res_ff <= mk_res(ST_INSERTED, item_ff.req.timer_id,
                                   best_ff[TIME_W-1:0], 1'b1);
               end
            end
            B_SCAN: begin
               if (scan_pend_ff && (cnt_rd_ff != '0) &&
                   (!found_ff || (tag_rd_ff < best_tag_ff))) begin
                  found_ff    <= 1'b1;
                  bs_ff       <= scan_idx_ff;
                  best_tag_ff <= tag_rd_ff;
               end
               if (scan_addr_ff == SLOT_CNT) begin
                  scan_pend_ff <= 1'b0;
                  state_ff     <= B_DUE;
               end else begin
                  scan_pend_ff <= 1'b1;
                  scan_idx_ff  <= scan_addr_ff[SW-1:0];
                  scan_addr_ff <= scan_addr_ff + NW'(1);
               end
            end
            B_DUE: begin
               priority if (!found_ff) begin
                  res_ff   <= mk_res(ST_NOTHING_DUE, '0, '0, 1'b1);
                  ret_ff   <= B_IDLE;
                  state_ff <= B_EMIT;
               end else if ({1'b0, best_tag_ff} > due_lim) begin
                  res_ff   <= mk_res(ST_NOTHING_DUE, '0, best_tag_ff, 1'b1);
                  ret_ff   <= B_IDLE;
                  state_ff <= B_EMIT;
               end else begin
                  state_ff <= B_HEAD_RD;
               end
            end
            B_HEAD_RD: state_ff <= B_HEAD;
            B_HEAD: begin
               cur_id_ff <= head_rd_ff;
               state_ff  <= B_UNL0;
            end
            B_EMIT: begin
               if (out_free) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ret_ff;
               end
            end
         endcase
      end
   end

   a_unlink_armed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_UNL2) |-> armed_ff[cur_id_ff])
      else $error("unlink of a timer that is not armed");

   a_place_disarmed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PLACE && !place_clash) |-> !armed_ff[cur_id_ff])
      else $error("timer linked twice");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_fire_more: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT && out_free && ret_ff == B_HEAD_RD) |=>
         (rsp_valid_ff && !rsp_data_ff.last))
      else $error("fired timer with more to follow marked last");

endmodule
`default_nettype wire

// ----- hdl/bucketed_timer_wheel.sv -----
`default_nettype none
// channel   dir  handshake              payload
// req       in   req_valid/req_ready    req_data   (btw_pkg::req_type)
// rsp       out  rsp_valid/rsp_ready    rsp_data   (btw_pkg::rsp_type)
// csr       in   csr_we                 csr_index, csr_wdata
//
// one item at a time, using the shared serial divider
// insert: 1 to 3 divisions plus a read and an evaluate per load-spreading candidate, up to NUM_SLOTS
// tick: a scan of all NUM_SLOTS buckets finds the earliest, then its timers fire one at a time if it is due
// after reset the bucket counts of all NUM_SLOTS slots are cleared before the first item
// a two-entry queue keeps taking transfers, until it is full, while the back end or rsp_ready stalls
module bucketed_timer_wheel import btw_pkg::*; #(
   parameter int NUM_SLOTS  = 256,
   parameter int MAX_TIMERS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   logic [CFG_W-1:0] bucket_width_ff;
   logic [CFG_W-1:0] early_window_ff;
   logic [CFG_W-1:0] width_eff;
   logic             q_valid;
   item_type         q_item;
   logic             q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_width_ff <= BUCKET_WIDTH_RST;
         early_window_ff <= EARLY_WINDOW_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_BUCKET_WIDTH) begin
            bucket_width_ff <= csr_wdata;
         end
         if (csr_index == CSR_EARLY_WINDOW) begin
            early_window_ff <= csr_wdata;
         end
      end
   end

   // zero width behaves as one
   assign width_eff = (bucket_width_ff == '0) ? CFG_W'(1) : bucket_width_ff;

   btw_front #(
      .MAX_TIMERS (MAX_TIMERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   btw_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .MAX_TIMERS (MAX_TIMERS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .width_eff    (width_eff),
      .early_window (early_window_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire
